// ===== src/wpsp_pkg.sv =====
`timescale 1ns / 1ps
// wpsp_pkg: shared types and constants for the WAV PCM stream parser.
// Used by wpsp_fixed and wav_pcm_stream_parser_top; depends on nothing.
package wpsp_pkg;

  localparam int MAX_SAMPLE_BYTES = 4;
  localparam int MAX_CHANNELS     = 2;
  localparam int OUT_WIDTH        = 32;

  // sample byte count (0..4) and bits per sample (0..32) as held internally
  localparam int SB_W   = 3;
  localparam int BITS_W = 6;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM = 16'd1;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_ERROR  = 2'd2
  } wpsp_kind_e;

  typedef enum logic [2:0] {
    ERR_NOT_RIFF  = 3'd0,
    ERR_NOT_WAVE  = 3'd1,
    ERR_NOT_PCM   = 3'd2,
    ERR_BAD_CHAN  = 3'd3,
    ERR_BAD_WIDTH = 3'd4
  } wpsp_err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } wpsp_in_t;

  typedef struct packed {
    wpsp_kind_e         kind;
    logic               channel;
    logic signed [31:0] sample_q31;
    logic               last_sample;
    wpsp_err_e          error_code;
    logic [31:0]        sample_rate;
    logic [1:0]         num_channels;
    logic [15:0]        bits_per_sample;
    logic [31:0]        data_bytes;
  } wpsp_out_t;

  // sample format as seen by the converter
  typedef struct packed {
    logic [SB_W-1:0]   sample_bytes;
    logic [BITS_W-1:0] sample_bits;
  } wpsp_fmt_t;

endpackage

// ===== src/wpsp_fixed.sv =====
`timescale 1ns / 1ps
// wpsp_fixed: little-endian PCM sample word to saturated fixed-point value.
// Depends on wpsp_pkg.
module wpsp_fixed #(
  parameter int MaxSampleBytes = wpsp_pkg::MAX_SAMPLE_BYTES,
  parameter int OutWidth       = wpsp_pkg::OUT_WIDTH
) (
  input  logic [8*MaxSampleBytes-1:0] acc_i,
  input  wpsp_pkg::wpsp_fmt_t         fmt_i,
  output logic signed [31:0]          q31_o
);

  localparam logic signed [63:0] SatHi = (64'sd1 <<< (OutWidth - 1)) - 64'sd1;
  localparam logic signed [63:0] SatLo = -SatHi - 64'sd1;
  localparam logic [wpsp_pkg::BITS_W-1:0] OutBits = wpsp_pkg::BITS_W'(OutWidth);

  logic [3:0][7:0]    bytes;
  logic               sign;
  logic signed [31:0] val;
  logic signed [63:0] wide;
  logic signed [63:0] shifted;
  logic signed [63:0] sat;

  always_comb begin
    bytes = 32'(acc_i);
    // 8-bit PCM is offset binary
    if (fmt_i.sample_bytes == wpsp_pkg::SB_W'(1)) begin
      bytes[0][7] = ~bytes[0][7];
    end
    case (fmt_i.sample_bytes)
      wpsp_pkg::SB_W'(1): sign = bytes[0][7];
      wpsp_pkg::SB_W'(2): sign = bytes[1][7];
      wpsp_pkg::SB_W'(3): sign = bytes[2][7];
      default:            sign = bytes[3][7];
    endcase
    for (int i = 0; i < 4; i++) begin
      if (fmt_i.sample_bytes != '0 && wpsp_pkg::SB_W'(i) >= fmt_i.sample_bytes) begin
        bytes[i] = {8{sign}};
      end
    end
    val  = signed'(bytes);
    wide = signed'({{32{val[31]}}, val});
    if (fmt_i.sample_bits <= OutBits) begin
      shifted = wide <<< (OutBits - fmt_i.sample_bits);
    end else begin
      shifted = wide >>> (fmt_i.sample_bits - OutBits);
    end
    if (shifted > SatHi) begin
      sat = SatHi;
    end else if (shifted < SatLo) begin
      sat = SatLo;
    end else begin
      sat = shifted;
    end
    q31_o = 32'(sat);
  end

endmodule

// ===== src/wav_pcm_stream_parser_top.sv =====
`timescale 1ns / 1ps
// wav_pcm_stream_parser_top: RIFF/WAVE PCM byte parser with sample output.
// Depends on wpsp_pkg and wpsp_fixed.
//
//  channel | handshake                | payload
//  --------+--------------------------+--------------------------------
//  in      | in_valid_i / in_ready_o   | in_i  (wpsp_in_t, one file byte)
//  out     | out_valid_o / out_ready_i | out_o (wpsp_out_t, one result)
//
// One byte per cycle while the output is not stalled; a taken byte passes the input
// register, then the parse step into the result register.
// The parse step runs when the result register is empty or being drained.
// Reset clears all parser state; file_start clears it again for its byte.
// Stalls on the output back up through the input register.
module wav_pcm_stream_parser_top #(
  parameter int MaxSampleBytes = wpsp_pkg::MAX_SAMPLE_BYTES,
  parameter int MaxChannels    = wpsp_pkg::MAX_CHANNELS,
  parameter int OutWidth       = wpsp_pkg::OUT_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wpsp_pkg::wpsp_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wpsp_pkg::wpsp_out_t out_o
);

  localparam int AccW  = 8 * MaxSampleBytes;
  localparam int SbW   = wpsp_pkg::SB_W;
  localparam int BitsW = wpsp_pkg::BITS_W;

  typedef enum logic [15:0] {
    PH_RIFF     = 16'h0001,
    PH_RIFFSIZE = 16'h0002,
    PH_WAVE     = 16'h0004,
    PH_ID       = 16'h0008,
    PH_SKIPSIZE = 16'h0010,
    PH_SKIP     = 16'h0020,
    PH_FMTSIZE  = 16'h0040,
    PH_FORMAT   = 16'h0080,
    PH_CHAN     = 16'h0100,
    PH_RATE     = 16'h0200,
    PH_BRATE    = 16'h0400,
    PH_ALIGN    = 16'h0800,
    PH_BITS     = 16'h1000,
    PH_DATASIZE = 16'h2000,
    PH_DATA     = 16'h4000,
    PH_HALT     = 16'h8000
  } phase_e;

  // handshake registers
  logic                in_vld_q;
  wpsp_pkg::wpsp_in_t  in_q;
  logic                out_vld_q, out_vld_d;
  wpsp_pkg::wpsp_out_t out_q;
  logic                fire;

  // parser state
  phase_e            phase_q, phase_d, cur_phase;
  logic [23:0]       field_q, field_d, cur_field;
  logic [1:0]        fpos_q, fpos_d, cur_fpos;
  logic [31:0]       skip_q, skip_d, cur_skip;
  logic [31:0]       fmtrem_q, fmtrem_d, cur_fmtrem;
  logic [1:0]        cc_q, cc_d, cur_cc;
  logic [BitsW-1:0]  bits_q, bits_d, cur_bits;
  logic [SbW-1:0]    sb_q, sb_d, cur_sb;
  logic [31:0]       rate_q, rate_d, cur_rate;
  logic [31:0]       drem_q, drem_d, cur_drem;
  logic [AccW-1:0]   acc_q, acc_d, cur_acc;
  logic [1:0]        spos_q, spos_d, cur_spos;
  logic              chpos_q, chpos_d, cur_chpos;
  logic              fco_q, fco_d, cur_fco;

  logic [7:0]          b;
  logic [31:0]         fld_v;
  logic                take_done;
  logic                uses_take;
  logic [15:0]         q_align;
  logic [3:0]          frame;
  logic [31:0]         drem_dec;
  logic [AccW-1:0]     acc_full;
  logic                res_vld;
  wpsp_pkg::wpsp_out_t res;
  wpsp_pkg::wpsp_fmt_t conv_fmt;
  logic signed [31:0]  conv_q31;

  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = res_vld;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  assign b = in_q.data_byte;

  // state seen by this byte: file_start restarts the parser
  always_comb begin
    if (in_q.file_start) begin
      cur_phase  = PH_RIFF;
      cur_field  = '0;
      cur_fpos   = '0;
      cur_skip   = '0;
      cur_fmtrem = '0;
      cur_cc     = '0;
      cur_bits   = '0;
      cur_sb     = '0;
      cur_rate   = '0;
      cur_drem   = '0;
      cur_acc    = '0;
      cur_spos   = '0;
      cur_chpos  = 1'b0;
      cur_fco    = 1'b0;
    end else begin
      cur_phase  = phase_q;
      cur_field  = field_q;
      cur_fpos   = fpos_q;
      cur_skip   = skip_q;
      cur_fmtrem = fmtrem_q;
      cur_cc     = cc_q;
      cur_bits   = bits_q;
      cur_sb     = sb_q;
      cur_rate   = rate_q;
      cur_drem   = drem_q;
      cur_acc    = acc_q;
      cur_spos   = spos_q;
      cur_chpos  = chpos_q;
      cur_fco    = fco_q;
    end
  end

  always_comb begin
    acc_full = cur_acc;
    for (int i = 0; i < MaxSampleBytes; i++) begin
      if (cur_spos == 2'(i)) begin
        acc_full[8*i +: 8] = b;
      end
    end
  end

  assign conv_fmt.sample_bytes = cur_sb;
  assign conv_fmt.sample_bits  = cur_bits;

  wpsp_fixed #(
    .MaxSampleBytes(MaxSampleBytes),
    .OutWidth      (OutWidth)
  ) u_fixed (
    .acc_i(acc_full),
    .fmt_i(conv_fmt),
    .q31_o(conv_q31)
  );

  always_comb begin
    fld_v    = {8'd0, cur_field} | (32'(b) << {cur_fpos, 3'b000});
    q_align  = (cur_cc == 2'd2) ? (fld_v[15:0] >> 1) : fld_v[15:0];
    frame    = (cur_cc == 2'd2) ? {cur_sb, 1'b0} : {1'b0, cur_sb};
    drem_dec = cur_drem - 32'd1;

    phase_d   = cur_phase;
    field_d   = cur_field;
    fpos_d    = cur_fpos;
    skip_d    = cur_skip;
    fmtrem_d  = cur_fmtrem;
    cc_d      = cur_cc;
    bits_d    = cur_bits;
    sb_d      = cur_sb;
    rate_d    = cur_rate;
    drem_d    = cur_drem;
    acc_d     = cur_acc;
    spos_d    = cur_spos;
    chpos_d   = cur_chpos;
    fco_d     = cur_fco;
    res       = '0;
    res_vld   = 1'b0;
    take_done = (cur_fpos == 2'd3);
    uses_take = 1'b1;

    if (cur_phase == PH_FORMAT || cur_phase == PH_CHAN || cur_phase == PH_RATE ||
        cur_phase == PH_BRATE || cur_phase == PH_ALIGN || cur_phase == PH_BITS) begin
      if (cur_fmtrem != '0) begin
        fmtrem_d = cur_fmtrem - 32'd1;
      end
    end
    if (cur_phase == PH_FORMAT || cur_phase == PH_CHAN ||
        cur_phase == PH_ALIGN || cur_phase == PH_BITS) begin
      take_done = (cur_fpos == 2'd1);
    end

    case (cur_phase)
      PH_RIFF: begin
        if (take_done) begin
          if (fld_v != wpsp_pkg::TAG_RIFF) begin
            res_vld        = 1'b1;
            res.kind       = wpsp_pkg::KIND_ERROR;
            res.error_code = wpsp_pkg::ERR_NOT_RIFF;
            phase_d        = PH_HALT;
          end else begin
            phase_d = PH_RIFFSIZE;
          end
        end
      end
      PH_RIFFSIZE: begin
        if (take_done) begin
          phase_d = PH_WAVE;
        end
      end
      PH_WAVE: begin
        if (take_done) begin
          if (fld_v != wpsp_pkg::TAG_WAVE) begin
            res_vld        = 1'b1;
            res.kind       = wpsp_pkg::KIND_ERROR;
            res.error_code = wpsp_pkg::ERR_NOT_WAVE;
            phase_d        = PH_HALT;
          end else begin
            phase_d = PH_ID;
          end
        end
      end
      PH_ID: begin
        if (take_done) begin
          if (cur_sb == '0 && fld_v == wpsp_pkg::TAG_FMT) begin
            phase_d = PH_FMTSIZE;
          end else if (cur_sb != '0 && fld_v == wpsp_pkg::TAG_DATA) begin
            phase_d = PH_DATASIZE;
          end else begin
            phase_d = PH_SKIPSIZE;
          end
        end
      end
      PH_SKIPSIZE: begin
        if (take_done) begin
          skip_d  = fld_v;
          phase_d = (fld_v != '0) ? PH_SKIP : PH_ID;
        end
      end
      PH_SKIP: begin
        uses_take = 1'b0;
        if (cur_skip != '0) begin
          skip_d = cur_skip - 32'd1;
        end
        if (skip_d == '0) begin
          phase_d = PH_ID;
        end
      end
      PH_FMTSIZE: begin
        if (take_done) begin
          fmtrem_d = fld_v;
          phase_d  = PH_FORMAT;
        end
      end
      PH_FORMAT: begin
        if (take_done) begin
          if (fld_v[15:0] != wpsp_pkg::FMT_PCM) begin
            res_vld        = 1'b1;
            res.kind       = wpsp_pkg::KIND_ERROR;
            res.error_code = wpsp_pkg::ERR_NOT_PCM;
            phase_d        = PH_HALT;
          end else begin
            phase_d = PH_CHAN;
          end
        end
      end
      PH_CHAN: begin
        if (take_done) begin
          if (fld_v[15:0] == '0 || fld_v[15:0] > 16'(MaxChannels)) begin
            res_vld        = 1'b1;
            res.kind       = wpsp_pkg::KIND_ERROR;
            res.error_code = wpsp_pkg::ERR_BAD_CHAN;
            phase_d        = PH_HALT;
          end else begin
            cc_d    = fld_v[1:0];
            phase_d = PH_RATE;
          end
        end
      end
      PH_RATE: begin
        if (take_done) begin
          rate_d  = fld_v;
          phase_d = PH_BRATE;
        end
      end
      PH_BRATE: begin
        if (take_done) begin
          phase_d = PH_ALIGN;
        end
      end
      PH_ALIGN: begin
        if (take_done) begin
          if (cur_cc != '0 && q_align != '0 && q_align <= 16'(MaxSampleBytes)) begin
            sb_d = SbW'(q_align);
          end else begin
            sb_d = '0;
          end
          phase_d = PH_BITS;
        end
      end
      PH_BITS: begin
        if (take_done) begin
          if (cur_sb == '0 || fld_v[15:0] == '0 ||
              fld_v[15:0] > 16'(8 * MaxSampleBytes)) begin
            res_vld        = 1'b1;
            res.kind       = wpsp_pkg::KIND_ERROR;
            res.error_code = wpsp_pkg::ERR_BAD_WIDTH;
            phase_d        = PH_HALT;
          end else begin
            bits_d  = BitsW'(fld_v[15:0]);
            skip_d  = fmtrem_d;
            phase_d = (fmtrem_d != '0) ? PH_SKIP : PH_ID;
          end
        end
      end
      PH_DATASIZE: begin
        if (take_done) begin
          drem_d              = fld_v;
          acc_d               = '0;
          spos_d              = '0;
          chpos_d             = 1'b0;
          phase_d             = (fld_v != '0) ? PH_DATA : PH_HALT;
          res_vld             = 1'b1;
          res.kind            = wpsp_pkg::KIND_FORMAT;
          res.sample_rate     = cur_rate;
          res.num_channels    = cur_cc;
          res.bits_per_sample = 16'(cur_bits);
          res.data_bytes      = fld_v;
        end
      end
      PH_DATA: begin
        uses_take = 1'b0;
        if (cur_spos == '0 && !cur_chpos) begin
          fco_d = (cur_drem >= 32'(frame));
        end
        drem_d = drem_dec;
        if (SbW'(cur_spos) + SbW'(1) >= cur_sb) begin
          if (fco_d) begin
            res_vld         = 1'b1;
            res.kind        = wpsp_pkg::KIND_SAMPLE;
            res.channel     = cur_chpos;
            res.sample_q31  = conv_q31;
            res.last_sample = (2'(cur_chpos) + 2'd1 >= cur_cc) && (drem_dec < 32'(frame));
          end
          acc_d   = '0;
          spos_d  = '0;
          chpos_d = (2'(cur_chpos) + 2'd1 >= cur_cc) ? 1'b0 : 1'b1;
        end else begin
          acc_d  = acc_full;
          spos_d = cur_spos + 2'd1;
        end
        if (drem_dec == '0) begin
          phase_d = PH_HALT;
        end
      end
      default: begin
        uses_take = 1'b0;
      end
    endcase

    if (uses_take) begin
      if (take_done) begin
        field_d = '0;
        fpos_d  = '0;
      end else begin
        field_d = fld_v[23:0];
        fpos_d  = cur_fpos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_RIFF;
      field_q  <= '0;
      fpos_q   <= '0;
      skip_q   <= '0;
      fmtrem_q <= '0;
      cc_q     <= '0;
      bits_q   <= '0;
      sb_q     <= '0;
      rate_q   <= '0;
      drem_q   <= '0;
      acc_q    <= '0;
      spos_q   <= '0;
      chpos_q  <= 1'b0;
      fco_q    <= 1'b0;
    end else if (fire) begin
      phase_q  <= phase_d;
      field_q  <= field_d;
      fpos_q   <= fpos_d;
      skip_q   <= skip_d;
      fmtrem_q <= fmtrem_d;
      cc_q     <= cc_d;
      bits_q   <= bits_d;
      sb_q     <= sb_d;
      rate_q   <= rate_d;
      drem_q   <= drem_d;
      acc_q    <= acc_d;
      spos_q   <= spos_d;
      chpos_q  <= chpos_d;
      fco_q    <= fco_d;
    end
  end

  a_sample_only_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_vld && res.kind == wpsp_pkg::KIND_SAMPLE
      |-> !in_q.file_start && phase_q == PH_DATA)
    else $error("sample item produced outside the data chunk");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_vld && res.kind == wpsp_pkg::KIND_ERROR |=> phase_q == PH_HALT)
    else $error("parser did not halt after an error item");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && out_vld_q && !out_ready_i)
    else $error("input stalled without a blocked result");

  a_byte_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> SbW'(spos_q) < sb_q)
    else $error("sample byte position beyond sample size");

endmodule

// ===== tb/wpsp_result_checker.sv =====
`timescale 1ns / 1ps
// wpsp_result_checker: watches both channels of the WAV PCM stream parser, predicts each
// result from the accepted bytes and compares it field by field. Depends on wpsp_pkg.
module wpsp_result_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  wpsp_pkg::wpsp_in_t  in_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  wpsp_pkg::wpsp_out_t out_i,
  output int                  mismatch_count_o,
  output int                  pending_o,
  output int                  sample_count_o,
  output int                  format_count_o,
  output int                  error_count_o
);

  typedef enum logic [3:0] {
    P_RIFF, P_RIFF_SIZE, P_WAVE, P_CHUNK_ID, P_SKIP_SIZE, P_SKIP, P_FMT_SIZE, P_FORMAT,
    P_CHAN, P_RATE, P_BYTE_RATE, P_ALIGN, P_BITS, P_DATA_SIZE, P_DATA, P_HALT
  } parse_phase_e;

  parse_phase_e phase;
  logic [31:0]  shift_reg;
  logic [1:0]   byte_pos;
  logic [31:0]  skip_cnt;
  logic [31:0]  fmt_cnt;
  logic [1:0]   chans;
  logic [15:0]  bits;
  logic [2:0]   nbytes;
  logic [31:0]  rate;
  logic [31:0]  data_left;
  logic [31:0]  accum;
  logic [1:0]   sbyte_pos;
  logic         chan_pos;
  logic         frame_ok;

  wpsp_pkg::wpsp_out_t awaited_results[$];

  function automatic void clear_parser();
    phase     = P_RIFF;
    shift_reg = '0;
    byte_pos  = '0;
    skip_cnt  = '0;
    fmt_cnt   = '0;
    chans     = '0;
    bits      = '0;
    nbytes    = '0;
    rate      = '0;
    data_left = '0;
    accum     = '0;
    sbyte_pos = '0;
    chan_pos  = 1'b0;
    frame_ok  = 1'b0;
  endfunction

  // little-endian field assembly; returns 1 once n bytes are in
  function automatic bit gather(input logic [7:0] b, input int n, output logic [31:0] val);
    shift_reg |= 32'(b) << (8 * byte_pos);
    val = shift_reg;
    if (int'(byte_pos) + 1 >= n) begin
      shift_reg = '0;
      byte_pos  = '0;
      return 1'b1;
    end
    byte_pos++;
    return 1'b0;
  endfunction

  function automatic wpsp_pkg::wpsp_out_t flag_error(input wpsp_pkg::wpsp_err_e code);
    wpsp_pkg::wpsp_out_t r;
    r            = '0;
    r.kind       = wpsp_pkg::KIND_ERROR;
    r.error_code = code;
    phase        = P_HALT;
    return r;
  endfunction

  function automatic logic [31:0] scale_to_q31();
    longint          v;
    longint          hi_lim;
    longint          lo_lim;
    longint unsigned u;
    int              w;
    hi_lim = (longint'(1) << (wpsp_pkg::OUT_WIDTH - 1)) - 1;
    lo_lim = -hi_lim - 1;
    if (nbytes == 3'd1) begin
      v = longint'(accum[7:0]) - 128;
    end else begin
      w = 8 * int'(nbytes);
      u = 64'(accum) & ((64'd1 << w) - 1);
      v = longint'(u);
      if (u[w-1]) v = v - (longint'(1) << w);
    end
    v = v * (longint'(1) << (wpsp_pkg::OUT_WIDTH - int'(bits)));
    if (v > hi_lim) v = hi_lim;
    if (v < lo_lim) v = lo_lim;
    return v[31:0];
  endfunction

  task automatic parse_wav_byte(input wpsp_pkg::wpsp_in_t it);
    logic [31:0]         v;
    logic [7:0]          b;
    logic [3:0]          frame_len;
    int                  q;
    wpsp_pkg::wpsp_out_t r;
    bit                  hit;
    r   = '0;
    hit = 1'b0;
    b   = it.data_byte;
    if (it.file_start) clear_parser();
    if (phase inside {[P_FORMAT:P_BITS]} && fmt_cnt != 0) fmt_cnt--;
    case (phase)
      P_RIFF: begin
        if (gather(b, 4, v)) begin
          if (v != wpsp_pkg::TAG_RIFF) begin
            r   = flag_error(wpsp_pkg::ERR_NOT_RIFF);
            hit = 1'b1;
          end else phase = P_RIFF_SIZE;
        end
      end
      P_RIFF_SIZE: if (gather(b, 4, v)) phase = P_WAVE;
      P_WAVE: begin
        if (gather(b, 4, v)) begin
          if (v != wpsp_pkg::TAG_WAVE) begin
            r   = flag_error(wpsp_pkg::ERR_NOT_WAVE);
            hit = 1'b1;
          end else phase = P_CHUNK_ID;
        end
      end
      P_CHUNK_ID: begin
        if (gather(b, 4, v)) begin
          if (nbytes == 0 && v == wpsp_pkg::TAG_FMT) phase = P_FMT_SIZE;
          else if (nbytes != 0 && v == wpsp_pkg::TAG_DATA) phase = P_DATA_SIZE;
          else phase = P_SKIP_SIZE;
        end
      end
      P_SKIP_SIZE: begin
        if (gather(b, 4, v)) begin
          skip_cnt = v;
          phase    = (v != 0) ? P_SKIP : P_CHUNK_ID;
        end
      end
      P_SKIP: begin
        if (skip_cnt != 0) skip_cnt--;
        if (skip_cnt == 0) phase = P_CHUNK_ID;
      end
      P_FMT_SIZE: begin
        if (gather(b, 4, v)) begin
          fmt_cnt = v;
          phase   = P_FORMAT;
        end
      end
      P_FORMAT: begin
        if (gather(b, 2, v)) begin
          if (v != 32'(wpsp_pkg::FMT_PCM)) begin
            r   = flag_error(wpsp_pkg::ERR_NOT_PCM);
            hit = 1'b1;
          end else phase = P_CHAN;
        end
      end
      P_CHAN: begin
        if (gather(b, 2, v)) begin
          if (v < 1 || v > wpsp_pkg::MAX_CHANNELS) begin
            r   = flag_error(wpsp_pkg::ERR_BAD_CHAN);
            hit = 1'b1;
          end else begin
            chans = v[1:0];
            phase = P_RATE;
          end
        end
      end
      P_RATE: begin
        if (gather(b, 4, v)) begin
          rate  = v;
          phase = P_BYTE_RATE;
        end
      end
      P_BYTE_RATE: if (gather(b, 4, v)) phase = P_ALIGN;
      P_ALIGN: begin
        if (gather(b, 2, v)) begin
          q      = (chans != 0) ? int'(v) / int'(chans) : 0;
          nbytes = (q >= 1 && q <= wpsp_pkg::MAX_SAMPLE_BYTES) ? 3'(q) : 3'd0;
          phase  = P_BITS;
        end
      end
      P_BITS: begin
        if (gather(b, 2, v)) begin
          if (nbytes == 0 || v == 0 || v > 8 * wpsp_pkg::MAX_SAMPLE_BYTES) begin
            r   = flag_error(wpsp_pkg::ERR_BAD_WIDTH);
            hit = 1'b1;
          end else begin
            bits     = v[15:0];
            skip_cnt = fmt_cnt;
            phase    = (skip_cnt != 0) ? P_SKIP : P_CHUNK_ID;
          end
        end
      end
      P_DATA_SIZE: begin
        if (gather(b, 4, v)) begin
          data_left         = v;
          accum             = '0;
          sbyte_pos         = '0;
          chan_pos          = 1'b0;
          phase             = (v != 0) ? P_DATA : P_HALT;
          r.kind            = wpsp_pkg::KIND_FORMAT;
          r.sample_rate     = rate;
          r.num_channels    = chans;
          r.bits_per_sample = bits;
          r.data_bytes      = v;
          hit               = 1'b1;
        end
      end
      P_DATA: begin
        frame_len = 4'(nbytes) * 4'(chans);
        if (sbyte_pos == 0 && !chan_pos) frame_ok = (data_left >= 32'(frame_len));
        accum |= 32'(b) << (8 * sbyte_pos);
        data_left--;
        if (int'(sbyte_pos) + 1 >= int'(nbytes)) begin
          if (frame_ok) begin
            r.kind        = wpsp_pkg::KIND_SAMPLE;
            r.channel     = chan_pos;
            r.sample_q31  = scale_to_q31();
            r.last_sample = (int'(chan_pos) + 1 >= int'(chans)) &&
                            (data_left < 32'(frame_len));
            hit           = 1'b1;
          end
          accum     = '0;
          sbyte_pos = '0;
          chan_pos  = (int'(chan_pos) + 1 >= int'(chans)) ? 1'b0 : 1'b1;
        end else begin
          sbyte_pos++;
        end
        if (data_left == 0) phase = P_HALT;
      end
      default: ;
    endcase
    if (hit) awaited_results = {awaited_results, r};
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count_o++;
    end
  endtask

  task automatic compare_result(input wpsp_pkg::wpsp_out_t got);
    wpsp_pkg::wpsp_out_t want;
    if (awaited_results.size() == 0) begin
      $error("unexpected result: kind %0d sample 0x%0h", got.kind, got.sample_q31);
      mismatch_count_o++;
      return;
    end
    want = awaited_results.pop_front();
    check_field("kind", want.kind, got.kind);
    check_field("channel", want.channel, got.channel);
    check_field("sample_q31", want.sample_q31, got.sample_q31);
    check_field("last_sample", want.last_sample, got.last_sample);
    check_field("error_code", want.error_code, got.error_code);
    check_field("sample_rate", want.sample_rate, got.sample_rate);
    check_field("num_channels", want.num_channels, got.num_channels);
    check_field("bits_per_sample", want.bits_per_sample, got.bits_per_sample);
    check_field("data_bytes", want.data_bytes, got.data_bytes);
    case (want.kind)
      wpsp_pkg::KIND_SAMPLE: sample_count_o++;
      wpsp_pkg::KIND_FORMAT: format_count_o++;
      default:               error_count_o++;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_parser();
      awaited_results.delete();
    end else begin
      if (in_valid_i && in_ready_i) parse_wav_byte(in_i);
      if (out_valid_i && out_ready_i) compare_result(out_i);
    end
    pending_o = awaited_results.size();
  end

endmodule

// ===== tb/wav_pcm_stream_parser_top_test.sv =====
`timescale 1ns / 1ps
// wav_pcm_stream_parser_top_test: builds WAV files byte by byte, well-formed and broken,
// feeds them to the parser under varied pacing and gives the verdict.
// Depends on wpsp_pkg, wav_pcm_stream_parser_top and wpsp_result_checker.
module wav_pcm_stream_parser_top_test;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                out_ready_i = 1'b0;
  wpsp_pkg::wpsp_in_t  in_i        = '0;
  logic                in_ready_o;
  logic                out_valid_o;
  wpsp_pkg::wpsp_out_t out_o;

  int mismatch_count;
  int pending_count;
  int sample_count;
  int format_count;
  int error_count;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int bytes_sent         = 0;
  int files_sent         = 0;

  logic [7:0] wav_bytes[$];

  wav_pcm_stream_parser_top i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_i,
    .out_valid_o,
    .out_ready_i,
    .out_o
  );

  wpsp_result_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i       (in_ready_o),
    .in_i,
    .out_valid_i      (out_valid_o),
    .out_ready_i,
    .out_i            (out_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count),
    .sample_count_o   (sample_count),
    .format_count_o   (format_count),
    .error_count_o    (error_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  initial begin
    #20_000_000;
    $error("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic put_le(input logic [31:0] v, input int n);
    for (int k = 0; k < n; k++) wav_bytes = {wav_bytes, v[8*k +: 8]};
  endtask

  // chunk that the parser must skip: data before fmt, fmt after fmt, or anything else
  task automatic put_junk(input bit after_fmt, input int len);
    logic [31:0] id;
    id = $urandom;
    if ($urandom_range(1)) id = after_fmt ? wpsp_pkg::TAG_FMT : wpsp_pkg::TAG_DATA;
    put_le(id, 4);
    put_le(len, 4);
    repeat (len) put_le($urandom, 1);
  endtask

  task automatic put_riff_head(input logic [31:0] riff_tag, input logic [31:0] wave_tag);
    put_le(riff_tag, 4);
    put_le($urandom, 4);
    put_le(wave_tag, 4);
  endtask

  task automatic put_fmt_and_data(input int fmt_code, input int chans,
                                  input logic [31:0] rate, input int align,
                                  input int bits, input int fmt_size,
                                  input int junk_post, input logic [31:0] data_size);
    put_le(wpsp_pkg::TAG_FMT, 4);
    put_le(fmt_size, 4);
    put_le(fmt_code, 2);
    put_le(chans, 2);
    put_le(rate, 4);
    put_le($urandom, 4);
    put_le(align, 2);
    put_le(bits, 2);
    if (fmt_size > 16) repeat (fmt_size - 16) put_le($urandom, 1);
    repeat (junk_post) put_junk(1'b1, $urandom_range(0, 6));
    put_le(wpsp_pkg::TAG_DATA, 4);
    put_le(data_size, 4);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fs);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= '{data_byte: b, file_start: fs};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_file(input bit mark_start);
    for (int k = 0; k < wav_bytes.size(); k++) send_byte(wav_bytes[k], mark_start && k == 0);
    wav_bytes.delete();
    files_sent++;
    case ((files_sent / 2) % 4)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 85; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 85; end
      default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
    endcase
  endtask

  task automatic send_random_file();
    int          defect;
    int          chans;
    int          nb;
    int          bits;
    int          fmt_size;
    int          frame_len;
    int          dsize;
    logic [31:0] riff_tag;
    logic [31:0] wave_tag;
    int          fmt_code;
    int          chan_field;
    int          align;
    int          bits_field;
    chans     = $urandom_range(1, 2);
    nb        = $urandom_range(1, 4);
    bits      = ($urandom_range(4) == 0) ? $urandom_range(1, 32) : 8 * nb;
    fmt_size  = ($urandom_range(3) == 0) ? $urandom_range(12, 24) : 16;
    frame_len = nb * chans;
    dsize     = $urandom_range(0, 10) * frame_len;
    if ($urandom_range(3) == 0) dsize += $urandom_range(0, frame_len - 1);
    defect    = ($urandom_range(3) == 0) ? $urandom_range(1, 7) : 0;
    riff_tag   = wpsp_pkg::TAG_RIFF;
    wave_tag   = wpsp_pkg::TAG_WAVE;
    fmt_code   = int'(wpsp_pkg::FMT_PCM);
    chan_field = chans;
    align      = nb * chans;
    bits_field = bits;
    case (defect)
      1: riff_tag ^= 32'd1 << $urandom_range(31);
      2: wave_tag ^= 32'd1 << $urandom_range(31);
      3: fmt_code = $urandom_range(1) ? 0 : int'($urandom_range(2, 65535));
      4: chan_field = $urandom_range(1) ? 0 : int'($urandom_range(3, 65535));
      5: begin
        case ($urandom_range(3))
          0: align = chans * int'($urandom_range(5, 16));
          1: align = chans - 1;
          2: bits_field = 0;
          default: bits_field = int'($urandom_range(33, 65535));
        endcase
      end
      default: ;
    endcase
    if (defect == 7) begin
      repeat ($urandom_range(1, 20)) put_le($urandom, 1);
      send_file($urandom_range(1));
      return;
    end
    put_riff_head(riff_tag, wave_tag);
    repeat ($urandom_range(0, 2)) put_junk(1'b0, $urandom_range(0, 6));
    put_fmt_and_data(fmt_code, chan_field, $urandom, align, bits_field, fmt_size,
                     $urandom_range(0, 1), dsize);
    repeat (dsize) put_le($urandom, 1);
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) put_le($urandom, 1);
    if (defect == 6) repeat ($urandom_range(1, wav_bytes.size() - 1)) void'(wav_bytes.pop_back());
    send_file(1'b1);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // mono 8-bit unsigned extremes, zero-size chunk ahead of fmt, first file without start flag
    put_riff_head(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
    put_junk(1'b0, 0);
    put_junk(1'b0, 3);
    put_fmt_and_data(int'(wpsp_pkg::FMT_PCM), 1, 32'hFFFF_FFFF, 1, 8, 16, 0, 4);
    put_le(32'h7FFF_8000, 4);
    send_file(1'b0);
    // stereo 16-bit extremes, then a partial frame
    put_riff_head(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
    put_fmt_and_data(int'(wpsp_pkg::FMT_PCM), 2, 44100, 4, 16, 16, 1, 11);
    put_le(32'h7FFF_8000, 4);
    put_le(32'hFFFF_0000, 4);
    put_le($urandom, 3);
    send_file(1'b1);
    // mono 24-bit, long fmt chunk, an extra chunk (fmt or random id) after the real one
    put_riff_head(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
    put_fmt_and_data(int'(wpsp_pkg::FMT_PCM), 1, 48000, 3, 24, 18, 1, 6);
    put_le(32'h80_0000, 3);
    put_le(32'h7F_FFFF, 3);
    send_file(1'b1);
    // stereo 32-bit extremes
    put_riff_head(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
    put_fmt_and_data(int'(wpsp_pkg::FMT_PCM), 2, 0, 8, 32, 16, 0, 8);
    put_le(32'h8000_0000, 4);
    put_le(32'h7FFF_FFFF, 4);
    send_file(1'b1);
    // 4-byte container with 1 valid bit: saturation at the positive limit
    put_riff_head(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
    put_fmt_and_data(int'(wpsp_pkg::FMT_PCM), 1, 8000, 4, 1, 16, 0, 12);
    put_le(32'h0000_0001, 4);
    put_le(32'hFFFF_FFFF, 4);
    put_le(32'h0000_0000, 4);
    send_file(1'b1);
    // 1-byte container declared 32 bits
    put_riff_head(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
    put_fmt_and_data(int'(wpsp_pkg::FMT_PCM), 1, 8000, 1, 32, 16, 0, 2);
    put_le(32'h0000_FF00, 2);
    send_file(1'b1);
    // short fmt chunk, 12 bits in 16
    put_riff_head(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
    put_fmt_and_data(int'(wpsp_pkg::FMT_PCM), 2, 22050, 4, 12, 14, 0, 4);
    put_le(32'h8000_7FF0, 4);
    send_file(1'b1);
    // empty data chunk, trailing bytes ignored
    put_riff_head(wpsp_pkg::TAG_RIFF, wpsp_pkg::TAG_WAVE);
    put_fmt_and_data(int'(wpsp_pkg::FMT_PCM), 1, 16000, 2, 16, 16, 0, 0);
    put_le($urandom, 3);
    send_file(1'b1);
    // one file per error case
    for (int e = 0; e < 8; e++) begin
      put_riff_head((e == 0) ? wpsp_pkg::TAG_RIFF ^ 32'h1 : wpsp_pkg::TAG_RIFF,
                    (e == 1) ? wpsp_pkg::TAG_WAVE ^ 32'h8000_0000 : wpsp_pkg::TAG_WAVE);
      put_fmt_and_data((e == 2) ? 3 : int'(wpsp_pkg::FMT_PCM),
                       (e == 3) ? 0 : (e == 4) ? 3 : 1, 16000,
                       (e == 5) ? 5 : 2, (e == 6) ? 0 : (e == 7) ? 33 : 16, 16, 0, 4);
      put_le($urandom, 4);
      send_file(1'b1);
    end

    while (bytes_sent < 1150) send_random_file();
    in_valid_i <= 1'b0;

    while (pending_count != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    $display("Fed %0d bytes in %0d files, well-formed and broken, over four pacing modes.",
             bytes_sent, files_sent);
    $display("Matched %0d samples, %0d format reports and %0d error reports.",
             sample_count, format_count, error_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
